[sv/assert_macros.svh]
// Assertion macros for the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with synchronous active-low reset as disable.
`define LWM_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Condition that must never be seen out of reset.
`define LWM_NEVER(label, clk, rstn, cond, msg) \
    `LWM_ASSERT(label, clk, rstn, !(cond), msg)

`endif

[sv/lwm_pkg.sv]
// Shared types and constants for the LIKE wildcard matcher.
`default_nettype none
package lwm_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TEXT   = 2'd2,
        OP_EMPTY  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_LITERAL = 2'd0,
        KIND_ANY_ONE = 2'd1,
        KIND_ANY_SEQ = 2'd2
    } kind_t;

    localparam logic [7:0] BYTE_PERCENT    = 8'h25;
    localparam logic [7:0] BYTE_UNDERSCORE = 8'h5F;
    localparam logic [7:0] BYTE_BACKSLASH  = 8'h5C;

    typedef struct packed {
        logic       fire;
        op_t        op;
        logic [7:0] data;
    } store_cmd_t;

endpackage
`default_nettype wire

[sv/like_wildcard_matcher_core.sv]
// Top level of the SQL LIKE wildcard matcher.
//
// Usage:
//  - s_ channel: one beat per item. s_tuser is the operation (clear pattern,
//    append pattern byte, text byte, empty row), s_tdata the byte, s_tlast
//    marks the final text byte of a row.
//  - m_ channel: one beat per row end (last text byte or empty row):
//    m_tdata[0] match (xor invert), m_tdata[1] pattern overflow.
//  - cfg channel: writes invert_result (NOT LIKE); cfg_ready is high out of
//    reset. Write only while the block is idle.
//  - Path: the input beat passes through the input register, then the result
//    register, to the result beat.
//  - Throughput: one item per cycle while no result is stalled. The prefix
//    vector step, with its log-depth '%' closure, is combinational between
//    the two registers.
//  - Stall: with m_tready low one result waits in the output register and
//    one more item waits in the input register; items that give no result
//    still pass through.
//  - Reset (aresetn low, synchronous): empty pattern, no pending escape, no
//    overflow, invert off; both channels read not ready / not valid.
`default_nettype none
module like_wildcard_matcher_core #(
    parameter int PATTERN_MAX = 32
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // input item stream
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic [1:0] s_tuser,   // [1:0] operation
    input  wire logic       s_tlast,   // last
    // result stream
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [0] match, [1] pattern_overflow, [7:2] zero
    // configuration
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [0:0] cfg_data   // [0] invert_result
);
    import lwm_pkg::*;

    localparam int CW = $clog2(PATTERN_MAX + 1);

    // input register
    logic       in_valid_reg;
    op_t        in_op_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // row state: fresh means "prefix zero only, closed over leading '%'"
    logic                 fresh_reg;
    logic [PATTERN_MAX:0] active_reg;

    // result register
    logic out_valid_reg, out_match_reg, out_ovf_reg;
    logic invert_reg;

    logic has_result, proc;
    store_cmd_t cmd;

    logic [PATTERN_MAX-1:0] seq_mask, step_mask;
    logic [PATTERN_MAX:0]   lead, cur, final_vec;
    logic [CW-1:0]          eff_count;
    logic                   eff_overflow, hit, row_start;

    assign has_result = (in_op_reg == OP_EMPTY) || ((in_op_reg == OP_TEXT) && in_last_reg);
    // the held item moves on unless its result would land on a stalled beat
    assign proc       = in_valid_reg && (!has_result || !out_valid_reg || m_tready);
    assign s_tready   = aresetn && (!in_valid_reg || proc);
    assign cfg_ready  = aresetn;

    assign cmd.fire = proc;
    assign cmd.op   = in_op_reg;
    assign cmd.data = in_byte_reg;

    lwm_pattern_store #(
        .PATTERN_MAX(PATTERN_MAX)
    ) u_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .seq_mask    (seq_mask),
        .step_mask   (step_mask),
        .lead        (lead),
        .eff_count   (eff_count),
        .eff_overflow(eff_overflow)
    );

    assign row_start = (in_op_reg == OP_EMPTY);
    assign cur       = (fresh_reg || row_start) ? lead : active_reg;

    lwm_prefix_step #(
        .PATTERN_MAX(PATTERN_MAX)
    ) u_step (
        .cur      (cur),
        .seq_mask (seq_mask),
        .step_mask(step_mask),
        .count    (eff_count),
        .row_start(row_start),
        .final_vec(final_vec),
        .hit      (hit)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (proc) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg   <= op_t'(s_tuser);
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // active-prefix vector
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fresh_reg <= 1'b1;
        end else if (proc) begin
            unique case (in_op_reg)
                OP_TEXT:                      fresh_reg <= in_last_reg;
                OP_CLEAR, OP_APPEND, OP_EMPTY: fresh_reg <= 1'b1;
                default:                      fresh_reg <= 1'b1;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && (in_op_reg == OP_TEXT) && !in_last_reg) begin
            active_reg <= final_vec;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc && has_result) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && has_result) begin
            out_match_reg <= hit ^ invert_reg;
            out_ovf_reg   <= eff_overflow;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            invert_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            invert_reg <= cfg_data[0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_ovf_reg, out_match_reg};

endmodule
`default_nettype wire

[sv/lwm_pattern_store.sv]
// Pattern element store: loader, escape handling, per-element match masks.
`default_nettype none
module lwm_pattern_store #(
    parameter int PATTERN_MAX = 32,
    localparam int CW = $clog2(PATTERN_MAX + 1)
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire lwm_pkg::store_cmd_t      cmd,
    output logic [PATTERN_MAX-1:0]        seq_mask,
    output logic [PATTERN_MAX-1:0]        step_mask,
    output logic [PATTERN_MAX:0]          lead,
    output logic [CW-1:0]                 eff_count,
    output logic                          eff_overflow
);
    import lwm_pkg::*;

    kind_t             kind_reg [PATTERN_MAX];
    logic [7:0]        char_reg [PATTERN_MAX];
    logic [CW-1:0]     count_reg, count_next;
    logic              pending_reg, pending_next;
    logic              ovf_reg, ovf_next;
    logic [PATTERN_MAX:0] lead_reg, lead_next;

    logic              is_row, full, flush;
    logic              add_en, wr_en;
    kind_t             add_kind;
    logic [7:0]        add_char;

    assign is_row = (cmd.op == OP_TEXT) || (cmd.op == OP_EMPTY);
    assign full   = (count_reg == CW'(PATTERN_MAX));
    assign flush  = is_row && pending_reg;

    // element decode for this beat
    always_comb begin
        add_en       = 1'b0;
        add_kind     = KIND_LITERAL;
        add_char     = cmd.data;
        pending_next = pending_reg;
        unique case (cmd.op)
            OP_CLEAR: begin
                pending_next = 1'b0;
            end
            OP_APPEND: begin
                if (pending_reg) begin
                    pending_next = 1'b0;
                    add_en       = 1'b1;
                end else if (cmd.data == BYTE_BACKSLASH) begin
                    pending_next = 1'b1;
                end else if (cmd.data == BYTE_PERCENT) begin
                    add_en   = 1'b1;
                    add_kind = KIND_ANY_SEQ;
                    add_char = '0;
                end else if (cmd.data == BYTE_UNDERSCORE) begin
                    add_en   = 1'b1;
                    add_kind = KIND_ANY_ONE;
                    add_char = '0;
                end else begin
                    add_en = 1'b1;
                end
            end
            OP_TEXT, OP_EMPTY: begin
                // dangling backslash becomes a literal
                pending_next = 1'b0;
                add_en       = pending_reg;
                add_char     = BYTE_BACKSLASH;
            end
            default: begin
                pending_next = pending_reg;
            end
        endcase
    end

    assign wr_en = cmd.fire && add_en && !full;

    always_comb begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        lead_next  = lead_reg;
        if (cmd.op == OP_CLEAR) begin
            count_next = '0;
            ovf_next   = 1'b0;
            lead_next  = (PATTERN_MAX + 1)'(1);
        end else if (add_en) begin
            if (full) begin
                ovf_next = 1'b1;
            end else begin
                count_next = count_reg + CW'(1);
                // leading run of '%' from prefix zero
                if (add_kind == KIND_ANY_SEQ) begin
                    for (int i = 0; i < PATTERN_MAX; i++) begin
                        if (count_reg == CW'(i) && lead_reg[i]) begin
                            lead_next[i+1] = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            pending_reg <= 1'b0;
            ovf_reg     <= 1'b0;
            lead_reg    <= (PATTERN_MAX + 1)'(1);
        end else if (cmd.fire) begin
            count_reg   <= count_next;
            pending_reg <= pending_next;
            ovf_reg     <= ovf_next;
            lead_reg    <= lead_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (wr_en && count_reg == CW'(i)) begin
                kind_reg[i] <= add_kind;
                char_reg[i] <= add_char;
            end
        end
    end

    // view with any pending backslash already committed
    assign eff_count    = (flush && !full) ? count_reg + CW'(1) : count_reg;
    assign eff_overflow = ovf_reg || (flush && full);
    assign lead         = lead_reg;

    always_comb begin
        kind_t      k;
        logic [7:0] c;
        logic       tail, valid;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            tail  = flush && !full && (count_reg == CW'(i));
            k     = tail ? KIND_LITERAL : kind_reg[i];
            c     = tail ? BYTE_BACKSLASH : char_reg[i];
            valid = CW'(i) < eff_count;
            seq_mask[i]  = valid && (k == KIND_ANY_SEQ);
            step_mask[i] = valid && ((k == KIND_ANY_ONE) ||
                                     ((k == KIND_LITERAL) && (c == cmd.data)));
        end
    end

endmodule
`default_nettype wire

[sv/lwm_prefix_step.sv]
// One text-byte step of the active-prefix vector with '%' closure.
`default_nettype none
module lwm_prefix_step #(
    parameter int PATTERN_MAX = 32,
    localparam int CW = $clog2(PATTERN_MAX + 1),
    localparam int LV = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX + 1) : 1
) (
    input  wire logic [PATTERN_MAX:0]   cur,
    input  wire logic [PATTERN_MAX-1:0] seq_mask,
    input  wire logic [PATTERN_MAX-1:0] step_mask,
    input  wire logic [CW-1:0]          count,
    input  wire logic                   row_start,
    output logic [PATTERN_MAX:0]        final_vec,
    output logic                        hit
);
    logic [PATTERN_MAX:0] nxt, closed_vec;

    always_comb begin
        nxt = '0;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            nxt[i]   = nxt[i] | (cur[i] & seq_mask[i]);
            nxt[i+1] = cur[i] & step_mask[i];
        end
    end

    // log-depth closure over runs of '%': p[i] spans the elements below i
    always_comb begin
        logic [PATTERN_MAX:0] v, p, vn, pn;
        v = nxt;
        p = {seq_mask, 1'b0};
        for (int l = 0; l < LV; l++) begin
            vn = v;
            pn = '0;
            for (int i = 0; i <= PATTERN_MAX; i++) begin
                if (i >= (1 << l)) begin
                    vn[i] = v[i] | (v[i - (1 << l)] & p[i]);
                    pn[i] = p[i] & p[i - (1 << l)];
                end
            end
            v = vn;
            p = pn;
        end
        closed_vec = v;
    end

    assign final_vec = row_start ? cur : closed_vec;
    assign hit       = final_vec[count];

endmodule
`default_nettype wire

[sv/lwm_checker.sv]
// Port-level checker for the LIKE wildcard matcher, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module lwm_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);
    // a stalled result beat holds
    `LWM_ASSERT(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "result beat changed while stalled")

    // a fresh result follows an input beat taken through the input and result registers
    `LWM_ASSERT(a_out_origin, aclk, aresetn, $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2), "result beat without input beat")

    // input backpressure only comes from a stalled result
    `LWM_ASSERT(a_in_stall, aclk, aresetn, !s_tready |-> (m_tvalid && !m_tready), "input stalled with output free")

    // padding bits of a result beat are zero
    `LWM_NEVER(a_out_pad, aclk, aresetn, m_tvalid && (m_tdata[7:2] != 6'b0), "result padding not zero")

endmodule

bind like_wildcard_matcher_core lwm_checker u_lwm_checker (.*);
`default_nettype wire

[sim/like_row_checker_pkg.sv]
// Row verdict predictor and result checker for the LIKE matcher testbench.
package like_row_checker_pkg;
    import lwm_pkg::*;

    localparam int ELEM_DEPTH = 32;

    typedef struct {
        bit match;
        bit overflow;
    } row_verdict_t;

    class like_row_checker;
        bit [7:0]          elem_char [ELEM_DEPTH];
        kind_t             elem_kind [ELEM_DEPTH];
        int unsigned       elem_count;
        bit                escape_open;
        bit [ELEM_DEPTH:0] live_prefixes;
        bit                overflowed;
        bit                invert;
        row_verdict_t      verdicts_due[$];
        int unsigned       mismatches;

        function new();
            clear_pattern();
            invert     = 1'b0;
            mismatches = 0;
        endfunction

        function void clear_pattern();
            elem_count    = 0;
            escape_open   = 1'b0;
            overflowed    = 1'b0;
            live_prefixes = 1;
        endfunction

        // Full store: element dropped, sticky overflow raised.
        function void push_element(kind_t kind, bit [7:0] ch);
            if (elem_count >= ELEM_DEPTH) begin
                overflowed = 1'b1;
            end else begin
                elem_kind[elem_count] = kind;
                elem_char[elem_count] = ch;
                elem_count++;
            end
        endfunction

        // A live prefix ending before a '%' also makes the prefix past it live.
        function bit [ELEM_DEPTH:0] close_runs(bit [ELEM_DEPTH:0] v);
            for (int i = 0; i < elem_count; i++) begin
                if (v[i] && elem_kind[i] == KIND_ANY_SEQ)
                    v[i+1] = 1'b1;
            end
            return v;
        endfunction

        function void note_input(op_t op, bit [7:0] data, bit last);
            bit [ELEM_DEPTH:0] cur;
            bit [ELEM_DEPTH:0] nxt;
            row_verdict_t      verdict;
            case (op)
                OP_CLEAR: begin
                    clear_pattern();
                end
                OP_APPEND: begin
                    live_prefixes = 1;
                    if (escape_open) begin
                        escape_open = 1'b0;
                        push_element(KIND_LITERAL, data);
                    end else if (data == BYTE_BACKSLASH) begin
                        escape_open = 1'b1;
                    end else if (data == BYTE_PERCENT) begin
                        push_element(KIND_ANY_SEQ, 8'h00);
                    end else if (data == BYTE_UNDERSCORE) begin
                        push_element(KIND_ANY_ONE, 8'h00);
                    end else begin
                        push_element(KIND_LITERAL, data);
                    end
                end
                default: begin
                    // trailing backslash becomes a literal backslash
                    if (escape_open) begin
                        escape_open = 1'b0;
                        push_element(KIND_LITERAL, BYTE_BACKSLASH);
                    end
                    if (op == OP_EMPTY) begin
                        nxt = 1;
                    end else begin
                        cur = close_runs(live_prefixes);
                        nxt = '0;
                        for (int i = 0; i < elem_count; i++) begin
                            if (cur[i]) begin
                                if (elem_kind[i] == KIND_ANY_SEQ)
                                    nxt[i] = 1'b1;
                                else if (elem_kind[i] == KIND_ANY_ONE || elem_char[i] == data)
                                    nxt[i+1] = 1'b1;
                            end
                        end
                        if (!last) begin
                            live_prefixes = nxt;
                            return;
                        end
                    end
                    cur              = close_runs(nxt);
                    verdict.match    = cur[elem_count] ^ invert;
                    verdict.overflow = overflowed;
                    verdicts_due     = {verdicts_due, verdict};
                    live_prefixes = 1;
                end
            endcase
        endfunction

        function void flag_mismatch(string what, int want, int got);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: %s expected %0d got %0d", what, want, got);
        endfunction

        function void check_result(bit [7:0] beat);
            row_verdict_t want;
            if (verdicts_due.size() == 0) begin
                flag_mismatch("result beat with no row outstanding, tdata", -1, beat);
                return;
            end
            want = verdicts_due.pop_front();
            if (beat[0] != want.match)
                flag_mismatch("match", want.match, beat[0]);
            if (beat[1] != want.overflow)
                flag_mismatch("pattern_overflow", want.overflow, beat[1]);
            if (beat[7:2] != 6'd0)
                flag_mismatch("tdata padding", 0, beat[7:2]);
        endfunction

        function int unsigned rows_waiting();
            return verdicts_due.size();
        endfunction
    endclass

endpackage

[sim/testbench.sv]
// Self-checking testbench for the LIKE wildcard matcher core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lwm_pkg::*;
    import like_row_checker_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;  // far above the slowest legal run
    localparam int DRAIN_CYCLES = 6;       // two-stage pipe plus margin
    localparam int PHASE_ITEMS  = 250;
    localparam int PHASES       = 5;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'h00;
    logic [1:0] s_tuser   = OP_CLEAR;
    logic       s_tlast   = 1'b0;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [0:0] cfg_data  = 1'b0;

    like_row_checker row_check;
    int unsigned     cycle_count = 0;
    int unsigned     items_sent  = 0;
    int unsigned     stall_left  = 0;
    bit              tx_quiet    = 1'b0;   // sender never gaps
    bit              rx_quiet    = 1'b0;   // receiver never stalls

    like_wildcard_matcher_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [7:0] data_byte
        .s_tuser   (s_tuser),   // [1:0] operation
        .s_tlast   (s_tlast),   // last
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [0] match, [1] pattern_overflow, [7:2] zero
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)   // [0] invert_result
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost row ends the run here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: sample at the rising edge, then pick a fresh stall length
    // for the next beat. Stalls only start after a beat, so a result waiting
    // in the output register backs up into the input register too.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            row_check.check_result(m_tdata);
            stall_left = rx_quiet ? 0 : $urandom_range(0, 8);
        end
    end

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else begin
            m_tready = 1'b1;
        end
    end

    // One input beat: optional gap, then hold valid until accepted. Inputs
    // change on the falling edge only; a back-to-back beat keeps valid high.
    task automatic send_item(op_t op, bit [7:0] data, bit last);
        int unsigned gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 8);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = data;
        s_tlast  = last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        row_check.note_input(op, data, last);
        items_sent++;
    endtask

    // Sender stops until every row verdict is back, then lets the pipe empty
    // of result-less items too.
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (row_check.rows_waiting() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_invert(bit value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        row_check.invert = value;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Bytes biased towards the wildcard and escape characters and a tiny
    // alphabet so that patterns and rows line up often.
    function automatic bit [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h61;
            1:       return 8'h62;
            2:       return BYTE_PERCENT;
            3:       return BYTE_UNDERSCORE;
            4:       return BYTE_BACKSLASH;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Clear then load a fresh pattern; now and then one long enough to
    // overrun the element store.
    task automatic load_pattern();
        int unsigned len;
        send_item(OP_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        len = ($urandom_range(0, 11) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 8);
        repeat (len) send_item(OP_APPEND, pick_byte(), 1'($urandom_range(0, 1)));
    endtask

    // A row shaped on the stored elements, with the odd corrupted literal and
    // the odd byte too many or too few, so both verdicts turn up.
    task automatic send_row();
        bit [7:0] text[$];
        for (int i = 0; i < row_check.elem_count; i++) begin
            case (row_check.elem_kind[i])
                KIND_LITERAL:
                    text = {text, (($urandom_range(0, 9) == 0) ? pick_byte()
                                                              : row_check.elem_char[i])};
                KIND_ANY_ONE:
                    text = {text, pick_byte()};
                default:
                    repeat ($urandom_range(0, 3)) text = {text, pick_byte()};
            endcase
        end
        case ($urandom_range(0, 7))
            0:       text = {text, pick_byte()};
            1:       if (text.size() > 0) void'(text.pop_back());
            default: ;
        endcase
        if (text.size() == 0) begin
            send_item(OP_EMPTY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else begin
            for (int j = 0; j < text.size(); j++)
                send_item(OP_TEXT, text[j], j == text.size() - 1);
        end
    endtask

    task automatic run_random(int unsigned target);
        int unsigned pick;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                send_item(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
            else if (pick < 22)
                load_pattern();
            else
                send_row();
        end
    endtask

    task automatic run_directed();
        // ignored data and last on clear; empty pattern against empty and
        // one-byte rows
        send_item(OP_CLEAR, 8'hFF, 1'b1);
        send_item(OP_EMPTY, 8'hA5, 1'b1);
        send_item(OP_TEXT,  8'h00, 1'b1);
        // lone backslash left pending, committed by the empty row
        send_item(OP_APPEND, BYTE_BACKSLASH, 1'b0);
        send_item(OP_EMPTY,  8'h00, 1'b0);
        send_item(OP_TEXT,   BYTE_BACKSLASH, 1'b1);
        // a byte after the flush starts a new element
        send_item(OP_APPEND, BYTE_PERCENT, 1'b1);
        send_item(OP_TEXT,   BYTE_BACKSLASH, 1'b0);
        send_item(OP_TEXT,   8'hFF, 1'b1);
        // a %% _ \% <FF>: wildcard runs, escaped percent, top byte
        send_item(OP_CLEAR,  8'h00, 1'b0);
        send_item(OP_APPEND, 8'h61, 1'b0);
        send_item(OP_APPEND, BYTE_PERCENT, 1'b0);
        send_item(OP_APPEND, BYTE_PERCENT, 1'b0);
        send_item(OP_APPEND, BYTE_UNDERSCORE, 1'b0);
        send_item(OP_APPEND, BYTE_BACKSLASH, 1'b0);
        send_item(OP_APPEND, BYTE_PERCENT, 1'b0);
        send_item(OP_APPEND, 8'hFF, 1'b0);
        send_item(OP_TEXT,   8'h61, 1'b0);
        send_item(OP_TEXT,   8'h00, 1'b0);
        send_item(OP_TEXT,   BYTE_PERCENT, 1'b0);
        send_item(OP_TEXT,   8'hFF, 1'b1);
        // append mid-row throws the partial row away
        send_item(OP_TEXT,   8'h61, 1'b0);
        send_item(OP_APPEND, BYTE_UNDERSCORE, 1'b0);
        send_item(OP_TEXT,   8'h61, 1'b1);
        // empty row mid-row gives the verdict for the empty row
        send_item(OP_TEXT,   8'h62, 1'b0);
        send_item(OP_EMPTY,  8'h00, 1'b0);
    endtask

    initial begin
        row_check = new();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        write_invert(1'b0);
        run_directed();

        // Phases: both extremes of the invert bit first, then random ones.
        // Phase 1 runs flat out on both sides, phase 3 only the receiver.
        for (int p = 0; p < PHASES; p++) begin
            drain();
            write_invert((p < 2) ? 1'(p == 0) : 1'($urandom_range(0, 1)));
            tx_quiet = (p == 1);
            rx_quiet = (p == 1) || (p == 3);
            run_random(items_sent + PHASE_ITEMS);
        end
        drain();

        if (row_check.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[like_wildcard_matcher_core.f]
+incdir+sv
sv/lwm_pkg.sv
sv/lwm_pattern_store.sv
sv/lwm_prefix_step.sv
sv/like_wildcard_matcher_core.sv
sv/lwm_checker.sv
sim/like_row_checker_pkg.sv
sim/testbench.sv
